// ===== hdl/spi_fram_slave_model_macros.svh =====
// ---------------------------------------------------------------------------
// SPI FRAM slave model: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SPI_FRAM_SLAVE_MODEL_MACROS_SVH
`define SPI_FRAM_SLAVE_MODEL_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define SFM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define SFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SFM_ASSERT_IMPL(lbl, ante, cons, msg)
`define SFM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/sfram_pkg.sv =====
// ---------------------------------------------------------------------------
// SPI FRAM slave model: package
// Opcodes, phase and command codes, ID sequence and shared types.
// ---------------------------------------------------------------------------
package sfram_pkg;

    // Opcodes
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_RDID  = 8'h9F;

    // ID sequence bytes
    localparam logic [7:0] ID_CONT = 8'h7F;
    localparam logic [7:0] ID_MFR  = 8'hC2;
    localparam logic [3:0] ID_LEN  = 4'd9;
    localparam logic [3:0] ID_POS_MFR   = 4'd6;
    localparam logic [3:0] ID_POS_FIRST = 4'd7;
    localparam logic [3:0] ID_POS_SECOND = 4'd8;

    // Transfer phase codes
    localparam logic [2:0] PH_IDLE = 3'd0;
    localparam logic [2:0] PH_A2   = 3'd1;
    localparam logic [2:0] PH_A1   = 3'd2;
    localparam logic [2:0] PH_A0   = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_ID   = 3'd5;
    localparam logic [2:0] PH_SKIP = 3'd6;

    // Command codes
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_ID    = 2'd3;

    // Configuration register indexes
    localparam logic [7:0] CFG_PRODUCT_ID_FIRST  = 8'd0;
    localparam logic [7:0] CFG_PRODUCT_ID_SECOND = 8'd1;

    // Memory access strobes from the controller
    typedef struct packed {
        logic we;
        logic re;
    } sfram_mem_req_t;

    function automatic logic [7:0] id_byte(input logic [3:0] pos,
                                           input logic [7:0] pid_first,
                                           input logic [7:0] pid_second);
        logic [7:0] b;
        if (pos < ID_POS_MFR)
            b = ID_CONT;
        else if (pos == ID_POS_MFR)
            b = ID_MFR;
        else if (pos == ID_POS_FIRST)
            b = pid_first;
        else if (pos == ID_POS_SECOND)
            b = pid_second;
        else
            b = 8'h00;
        return b;
    endfunction

endpackage

// ===== hdl/sfram_ram.sv =====
// ---------------------------------------------------------------------------
// SPI FRAM slave model: generic RAM
// Single-port synchronous RAM with registered read data.
// ---------------------------------------------------------------------------
module sfram_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/sfram_ctrl.sv =====
// ---------------------------------------------------------------------------
// SPI FRAM slave model: command controller
// Decode opcodes, collect the address and drive the memory strobes per byte.
// ---------------------------------------------------------------------------
module sfram_ctrl
    import sfram_pkg::*;
#(
    parameter int unsigned ADDR_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic                 kind,
    input  logic [7:0]           mosi,
    input  logic [7:0]           pid_first,
    input  logic [7:0]           pid_second,
    output sfram_mem_req_t       mem_req,
    output logic [ADDR_BITS-1:0] mem_addr,
    output logic [7:0]           miso,
    output logic                 latch
);

    logic [2:0]           phase_reg, phase_next;
    logic [1:0]           cmd_reg, cmd_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [3:0]           id_pos_reg, id_pos_next;
    logic                 latch_reg, latch_next;
    logic [ADDR_BITS-1:0] addr_shift;

    // Only the low address bits reach the memory, so keep just those.
    assign addr_shift = ADDR_BITS'({addr_reg, mosi});

    always_comb
    begin
        phase_next  = phase_reg;
        cmd_next    = cmd_reg;
        addr_next   = addr_reg;
        id_pos_next = id_pos_reg;
        latch_next  = latch_reg;
        mem_req     = '0;
        miso        = 8'h00;
        if (step)
        begin
            if (kind)
            begin
                // Release: end of a write drops the latch
                if (cmd_reg == CMD_WRITE)
                begin
                    latch_next = 1'b0;
                end
                phase_next  = PH_IDLE;
                cmd_next    = CMD_NONE;
                id_pos_next = 4'd0;
            end
            else
            begin
                case (phase_reg)
                    PH_IDLE:
                    begin
                        if (mosi == OP_WREN)
                        begin
                            latch_next = 1'b1;
                            cmd_next   = CMD_NONE;
                            phase_next = PH_SKIP;
                        end
                        else if (mosi == OP_WRITE || mosi == OP_READ)
                        begin
                            cmd_next   = (mosi == OP_WRITE) ? CMD_WRITE : CMD_READ;
                            addr_next  = '0;
                            phase_next = PH_A2;
                        end
                        else if (mosi == OP_RDID)
                        begin
                            cmd_next    = CMD_ID;
                            id_pos_next = 4'd0;
                            phase_next  = PH_ID;
                        end
                        else
                        begin
                            cmd_next   = CMD_NONE;
                            phase_next = PH_SKIP;
                        end
                    end
                    PH_A2:
                    begin
                        addr_next  = addr_shift;
                        phase_next = PH_A1;
                    end
                    PH_A1:
                    begin
                        addr_next  = addr_shift;
                        phase_next = PH_A0;
                    end
                    PH_A0:
                    begin
                        addr_next  = addr_shift;
                        phase_next = PH_DATA;
                    end
                    PH_DATA:
                    begin
                        if (cmd_reg == CMD_READ)
                        begin
                            mem_req.re = 1'b1;
                        end
                        else if (cmd_reg == CMD_WRITE && latch_reg)
                        begin
                            mem_req.we = 1'b1;
                        end
                        addr_next = addr_reg + ADDR_BITS'(1);
                    end
                    PH_ID:
                    begin
                        miso = id_byte(id_pos_reg, pid_first, pid_second);
                        if (id_pos_reg < ID_LEN)
                        begin
                            id_pos_next = id_pos_reg + 4'd1;
                        end
                    end
                    default:
                    begin
                        // Skip phase: ignore bytes until release
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            cmd_reg    <= CMD_NONE;
            addr_reg   <= '0;
            id_pos_reg <= 4'd0;
            latch_reg  <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cmd_reg    <= cmd_next;
            addr_reg   <= addr_next;
            id_pos_reg <= id_pos_next;
            latch_reg  <= latch_next;
        end
    end

    assign mem_addr = addr_reg;
    assign latch    = latch_next;

endmodule

// ===== hdl/spi_fram_slave_model.sv =====
// ---------------------------------------------------------------------------
// SPI FRAM slave model: top level
// Byte-level model of an SPI FRAM device with a synchronous backing store.
// ---------------------------------------------------------------------------
// Each request on the slave stream is one byte exchanged while chip select
// is low (tuser = 0) or one chip-select release (tuser = 1). Every request
// yields exactly one result on the master stream: the MISO byte and the
// write-enable latch after that byte. A request's result is registered
// straight into the output register; a read data byte first passes
// through the registered read port of the single-port backing RAM and
// then into the output register. A new request is taken once the output
// register is empty or being drained in the same cycle and no RAM read
// is pending, so a read holds off new requests. The RAM has no
// reset and no clearing pass: reading a location that was never written
// returns whatever the RAM holds. Write the product ID registers only
// while the block is idle.
// ---------------------------------------------------------------------------
`include "spi_fram_slave_model_macros.svh"

module spi_fram_slave_model
    import sfram_pkg::*;
#(
    parameter int unsigned ADDR_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    // Request stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] mosi_byte
    input  logic       s_tuser,   // [0] kind (1 = chip select release)
    // Result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] miso_byte
    output logic       m_tuser,   // [0] write_enabled
    // Configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_index,
    input  logic [7:0] cfg_data
);

    localparam int unsigned MEM_DEPTH = 1 << ADDR_BITS;

    logic                 s_accept;
    logic                 pend_reg;
    logic                 m_tvalid_reg;
    logic [7:0]           m_tdata_reg;
    logic                 m_tuser_reg;
    logic [7:0]           pid_first_reg;
    logic [7:0]           pid_second_reg;
    sfram_mem_req_t       mem_req;
    logic [ADDR_BITS-1:0] mem_addr;
    logic [7:0]           mem_rdata;
    logic [7:0]           ctrl_miso;
    logic                 ctrl_latch;

    // Hold off requests while a RAM read is in flight or the result slot is stuck
    assign s_tready  = !pend_reg && (!m_tvalid_reg || m_tready);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    sfram_ctrl #(
        .ADDR_BITS (ADDR_BITS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (s_accept),
        .kind       (s_tuser),
        .mosi       (s_tdata),
        .pid_first  (pid_first_reg),
        .pid_second (pid_second_reg),
        .mem_req    (mem_req),
        .mem_addr   (mem_addr),
        .miso       (ctrl_miso),
        .latch      (ctrl_latch)
    );

    sfram_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_req.we),
        .re    (mem_req.re),
        .addr  (mem_addr),
        .wdata (s_tdata),
        .rdata (mem_rdata)
    );

    // Control: pending read flag, output valid and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            pid_first_reg  <= 8'h00;
            pid_second_reg <= 8'h00;
        end
        else
        begin
            pend_reg <= s_accept && mem_req.re;
            if (pend_reg || (s_accept && !mem_req.re))
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_PRODUCT_ID_FIRST)
                begin
                    pid_first_reg <= cfg_data;
                end
                else if (cfg_index == CFG_PRODUCT_ID_SECOND)
                begin
                    pid_second_reg <= cfg_data;
                end
            end
        end
    end

    // Result payload: RAM byte when the read lands, otherwise the decoded byte
    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            m_tdata_reg <= mem_rdata;
            m_tuser_reg <= ctrl_latch;
        end
        else if (s_accept && !mem_req.re)
        begin
            m_tdata_reg <= ctrl_miso;
            m_tuser_reg <= ctrl_latch;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `SFM_ASSERT_IMPL(a_pend_blocks_input, pend_reg, !s_tready, "request taken during RAM read")
    `SFM_ASSERT_IMPL(a_pend_slot_free, pend_reg, !m_tvalid_reg, "result slot busy when read lands")
    `SFM_ASSERT_IMPL(a_ram_on_accept, mem_req.we || mem_req.re, s_accept, "RAM strobe without request")
    `SFM_ASSERT_NEXT(a_read_lands, s_accept && mem_req.re, pend_reg && !m_tvalid_reg, "read result lost")

endmodule
